### hdl/ptsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ptsp_pkg;

  localparam int DUTY_BITS = 16;
  localparam logic [31:0] DUTY_MASK = (32'd1 << DUTY_BITS) - 32'd1;

  localparam int DUTY_W  = 16;
  localparam int PWR_W   = 20;
  localparam int STAMP_W = 32;
  localparam int STEP_W  = 17;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 2;
  localparam int PROD_W  = PWR_W + DUTY_W;
  localparam int DIVR_W  = CFG_W + 4;
  localparam int DIV_STEPS = PROD_W;
  localparam int CNT_W   = $clog2(DIV_STEPS);

  localparam logic [IDX_W-1:0] CFG_RANGE_MIN  = 2'd0;
  localparam logic [IDX_W-1:0] CFG_RANGE_MAX  = 2'd1;
  localparam logic [IDX_W-1:0] CFG_FULL_SCALE = 2'd2;
  localparam logic [IDX_W-1:0] CFG_ATTACHED   = 2'd3;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } ptsp_state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic div_step;
    logic commit;
  } ptsp_cmd_t;

  typedef struct packed {
    logic need_map;
  } ptsp_stat_t;

  function automatic logic [DUTY_W-1:0] duty_mask(input logic [DUTY_W-1:0] v);
    return v & DUTY_MASK[DUTY_W-1:0];
  endfunction

endpackage
`default_nettype wire

### hdl/ptsp_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface ptsp_in_if import ptsp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               opcode;
  logic               timer_elapsed;
  logic               source_found;
  logic               source_reachable;
  logic [STAMP_W-1:0] update_stamp;
  logic               channel_present;
  logic [PWR_W-1:0]   power_reading;

  modport source (
    output valid, opcode, timer_elapsed, source_found, source_reachable,
           update_stamp, channel_present, power_reading,
    input  ready
  );
  modport sink (
    input  valid, opcode, timer_elapsed, source_found, source_reachable,
           update_stamp, channel_present, power_reading,
    output ready
  );
endinterface
`default_nettype wire

### hdl/ptsp_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface ptsp_out_if import ptsp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DUTY_W-1:0] duty_position;
  logic              duty_changed;

  modport source (output valid, duty_position, duty_changed, input ready);
  modport sink (input valid, duty_position, duty_changed, output ready);
endinterface
`default_nettype wire

### hdl/ptsp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module ptsp_ctrl import ptsp_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire ptsp_stat_t stat,
  output ptsp_cmd_t       cmd
);

  ptsp_state_t      state;
  ptsp_state_t      state_next;
  logic [CNT_W-1:0] cnt;
  logic             out_free;
  logic             div_last;

  assign out_free = !out_valid || out_ready;
  assign div_last = (cnt == CNT_W'(DIV_STEPS - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        state_next = stat.need_map ? ST_DIV : ST_FIN;
      end
      ST_DIV: begin
        if (div_last) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_MUL: cmd.mul = 1'b1;
      ST_DIV: cmd.div_step = 1'b1;
      ST_FIN: cmd.commit = out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.mul) begin
        cnt <= '0;
      end else if (cmd.div_step) begin
        cnt <= cnt + CNT_W'(1);
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

### hdl/ptsp_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module ptsp_dp import ptsp_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_data,
  input  wire logic               opcode,
  input  wire logic               timer_elapsed,
  input  wire logic               source_found,
  input  wire logic               source_reachable,
  input  wire logic [STAMP_W-1:0] update_stamp,
  input  wire logic               channel_present,
  input  wire logic [PWR_W-1:0]   power_reading,
  input  wire ptsp_cmd_t          cmd,
  output ptsp_stat_t              stat,
  output logic [DUTY_W-1:0]       duty_position,
  output logic                    duty_changed
);

  logic [DUTY_W-1:0]  range_min;
  logic [DUTY_W-1:0]  range_max;
  logic [CFG_W-1:0]   full_scale;
  logic               attached;

  logic [DUTY_W-1:0]  current_duty;
  logic [STEP_W-1:0]  sweep_step;
  logic               sweep_active;
  logic [STAMP_W-1:0] seen_stamp;

  logic               op_r;
  logic               elapsed_r;
  logic               found_r;
  logic               reach_r;
  logic [STAMP_W-1:0] stamp_r;
  logic               chan_r;
  logic [PWR_W-1:0]   power_r;

  logic [PROD_W-1:0]  quo;
  logic [DIVR_W-1:0]  rem;

  logic               desc;
  logic [DUTY_W-1:0]  mag;
  logic [DIVR_W-1:0]  divisor;
  logic [DIVR_W:0]    rem_shift;
  logic [DIVR_W:0]    trial;
  logic               fs_zero;
  logic               sat;
  logic [DUTY_W-1:0]  q_clamp;
  logic [DUTY_W-1:0]  mapped;
  logic [STEP_W-1:0]  step_inc;
  logic [STEP_W-1:0]  step_dec;

  logic [DUTY_W-1:0]  pos;
  logic [STEP_W-1:0]  sweep_step_next;
  logic               sweep_active_next;
  logic [DUTY_W-1:0]  current_duty_next;
  logic [STAMP_W-1:0] seen_stamp_next;
  logic               changed_next;

  assign desc      = range_min > range_max;
  assign mag       = desc ? (range_min - range_max) : (range_max - range_min);
  assign divisor   = {full_scale, 4'b0000};
  assign fs_zero   = (full_scale == '0);
  assign rem_shift = {rem, quo[PROD_W-1]};
  assign trial     = rem_shift - {1'b0, divisor};

  assign sat      = (|quo[PROD_W-1:DUTY_W]) || (quo[DUTY_W-1:0] >= mag);
  assign q_clamp  = sat ? mag : quo[DUTY_W-1:0];
  assign mapped   = desc ? (range_min - q_clamp) : (range_min + q_clamp);
  assign step_inc = sweep_step + STEP_W'(1);
  assign step_dec = sweep_step - STEP_W'(1);

  assign stat.need_map = (op_r == OP_TICK) && !sweep_active && attached && found_r &&
                         reach_r && (stamp_r != seen_stamp) && chan_r && !fs_zero;

  always_comb begin
    pos               = current_duty;
    sweep_step_next   = sweep_step;
    sweep_active_next = sweep_active;
    seen_stamp_next   = seen_stamp;
    current_duty_next = current_duty;
    changed_next      = 1'b0;
    if (op_r == OP_START) begin
      sweep_step_next   = {1'b0, range_min};
      sweep_active_next = 1'b1;
      current_duty_next = duty_mask(range_max);
    end else begin
      priority if (sweep_active) begin
        if (elapsed_r) begin
          if (desc) begin
            if (sweep_step <= {1'b0, range_max}) begin
              sweep_active_next = 1'b0;
              sweep_step_next   = '0;
              pos               = range_min;
            end else begin
              sweep_step_next = step_dec;
              pos             = step_dec[DUTY_W-1:0];
            end
          end else begin
            if (step_inc > {1'b0, range_max}) begin
              sweep_active_next = 1'b0;
              sweep_step_next   = '0;
              pos               = range_min;
            end else begin
              sweep_step_next = step_inc;
              pos             = step_inc[DUTY_W-1:0];
            end
          end
        end
      end else if (!attached || !found_r || !reach_r) begin
        pos = range_min;
      end else if (stamp_r == seen_stamp) begin
        pos = current_duty;
      end else begin
        seen_stamp_next = stamp_r;
        if (!chan_r) begin
          pos = range_min;
        end else if (fs_zero) begin
          pos = range_max;
        end else begin
          pos = mapped;
        end
      end
      pos               = duty_mask(pos);
      changed_next      = (pos != current_duty);
      current_duty_next = pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      range_min    <= '0;
      range_max    <= '1;
      full_scale   <= CFG_W'(1000);
      attached     <= 1'b1;
      current_duty <= '0;
      sweep_step   <= '0;
      sweep_active <= 1'b0;
      seen_stamp   <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_RANGE_MIN:  range_min  <= cfg_data;
          CFG_RANGE_MAX:  range_max  <= cfg_data;
          CFG_FULL_SCALE: full_scale <= cfg_data;
          CFG_ATTACHED:   attached   <= cfg_data[0];
          default:        attached   <= attached;
        endcase
      end
      if (cmd.commit) begin
        current_duty <= current_duty_next;
        sweep_step   <= sweep_step_next;
        sweep_active <= sweep_active_next;
        seen_stamp   <= seen_stamp_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= opcode;
      elapsed_r <= timer_elapsed;
      found_r   <= source_found;
      reach_r   <= source_reachable;
      stamp_r   <= update_stamp;
      chan_r    <= channel_present;
      power_r   <= power_reading;
    end
    if (cmd.mul) begin
      quo <= PROD_W'(power_r) * PROD_W'(mag);
      rem <= '0;
    end else if (cmd.div_step) begin
      if (!trial[DIVR_W]) begin
        rem <= trial[DIVR_W-1:0];
        quo <= {quo[PROD_W-2:0], 1'b1};
      end else begin
        rem <= rem_shift[DIVR_W-1:0];
        quo <= {quo[PROD_W-2:0], 1'b0};
      end
    end
    if (cmd.commit) begin
      duty_position <= current_duty_next;
      duty_changed  <= changed_next;
    end
  end

endmodule
`default_nettype wire

### hdl/power_to_servo_position_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Word
// reading   in         opcode, timer_elapsed, source flags, update_stamp,
//                      channel_present, power_reading
// duty      out        duty_position, duty_changed
// cfg_*     in         register write: cfg_write, cfg_index, cfg_data
//
// A word that needs a fresh power mapping passes through the multiply state, the
// bit-serial divider state and the commit state after acceptance; every other
// word passes through the multiply state and the commit state only. The next word
// can be accepted in the cycle after the commit, so one word is in flight at a time.
// A result that has not been taken holds back the commit and with it the input.
// Reset is synchronous and restores the register defaults and the mapper state.
module power_to_servo_position_core import ptsp_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_write,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  ptsp_in_if.sink               reading,
  ptsp_out_if.source            duty
);

  ptsp_cmd_t  cmd;
  ptsp_stat_t stat;

  ptsp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (reading.valid),
    .in_ready  (reading.ready),
    .out_valid (duty.valid),
    .out_ready (duty.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ptsp_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .opcode           (reading.opcode),
    .timer_elapsed    (reading.timer_elapsed),
    .source_found     (reading.source_found),
    .source_reachable (reading.source_reachable),
    .update_stamp     (reading.update_stamp),
    .channel_present  (reading.channel_present),
    .power_reading    (reading.power_reading),
    .cmd              (cmd),
    .stat             (stat),
    .duty_position    (duty.duty_position),
    .duty_changed     (duty.duty_changed)
  );

endmodule
`default_nettype wire
